// ===== rtl/lwcc_pkg.sv =====
// ============================================================================
// lwcc_pkg: shared types and constants of the cluster centroid block
// Field widths, fixed-point constants and the record passed from the
// accumulating front end to the division back end.
// ============================================================================
package lwcc_pkg;

    // Input and output field widths
    localparam int unsigned POS_W    = 6;
    localparam int unsigned ENERGY_W = 16;
    localparam int unsigned AMP_W    = 24;
    localparam int unsigned WGT_W    = 12;
    localparam int unsigned CENT_W   = 14;

    // Stream payload widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 32;

    // Accumulator widths
    localparam int unsigned SUMP_W = 32;
    localparam int unsigned SUMW_W = 24;

    // log2 result: 5-bit integer part, 16-bit fraction
    localparam int unsigned LOG_INT_W  = 5;
    localparam int unsigned LOG_FRAC_W = 16;
    localparam int unsigned LOG_W      = LOG_INT_W + LOG_FRAC_W;

    // ln 2 in Q0.16, as a signed multiplier operand
    localparam logic signed [16:0] LN2_Q16 = 17'sd45426;

    // Weight saturation level
    localparam logic [WGT_W-1:0] WEIGHT_MAX = 12'd4095;

    // Reset value of the weight offset (4.5 in Q4.8)
    localparam logic [WGT_W-1:0] LOG_WEIGHT_RESET = 12'd1152;

    // Division: numerator is the position sum shifted left by 8
    localparam int unsigned FRAC_SHIFT = 8;
    localparam int unsigned NUM_W      = SUMP_W + FRAC_SHIFT;
    localparam int unsigned DIV_STEPS  = NUM_W;

    // Depth of the queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 2;

    // Closed cluster sums handed to the back end
    typedef struct packed {
        logic [SUMP_W-1:0] sum_x;
        logic [SUMP_W-1:0] sum_z;
        logic [SUMW_W-1:0] sum_w;
    } sums_t;

endpackage

// ===== rtl/log_weighted_cluster_centroid.sv =====
// ============================================================================
// log_weighted_cluster_centroid: logarithmic weighted cluster centroid
// Streams calorimeter cells in and gives one centroid per cluster.
// ============================================================================
// Usage
//   Input stream s_*: one transaction per cell, s_tlast on the last cell of
//   a cluster. Output stream m_*: one transaction per cluster with the
//   Q6.8 centroid; m_tuser is 0 when the weight sum was zero, and the
//   centroid fields are then zero.
//   cfg_*: writes the 12-bit weight offset W0 (Q4.8); cfg_ready is always
//   high. Write it only while no cluster is in flight.
// Processing
//   A cell with nonzero energy and amplitude, within the first MAX_CELLS of
//   its cluster, is accepted, then runs the two log2 units (the normalizing
//   shift search, the squaring steps through their 32x32 multiplier, then a
//   completion flag), then forms the weight and accumulates. Other cells
//   skip these steps. The front end takes no new cell until a cell is done.
//   Once the front end closes the cluster (right after the last cell, or
//   once that cell's weight is accumulated if it carries one), the sums go
//   into the queue, are popped, pass the restoring divider and are loaded
//   into the output register. A zero weight sum skips the divider. A
//   two-entry queue lets the next cluster accumulate.
// Reset clears all accumulators and queues and sets W0 to 4.5. A stalled
// receiver holds the output register; the divider and then the front end
// stop once the queue fills.
// ============================================================================
module log_weighted_cluster_centroid #(
    parameter int unsigned MAX_CELLS = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // cell_x[5:0], cell_z[11:6], cell_energy[27:12], cluster_amp[51:28], zero pad
    input  logic [lwcc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tlast,
    // centroid_x[13:0], centroid_z[27:14], zero pad
    output logic [lwcc_pkg::M_DATA_W-1:0] m_tdata,
    // centroid_valid[0]
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lwcc_pkg::WGT_W-1:0]    cfg_data
);
    import lwcc_pkg::*;

    logic [WGT_W-1:0] log_weight_reg;
    logic             fq_valid, fq_ready;
    sums_t            fq_data;
    logic             qd_valid, qd_ready;
    sums_t            qd_data;

    // Weight offset register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_weight_reg <= LOG_WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            log_weight_reg <= cfg_data;
        end
    end

    lwcc_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .log_weight (log_weight_reg),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    lwcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qd_valid),
        .pop_ready  (qd_ready),
        .pop_data   (qd_data)
    );

    lwcc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qd_valid),
        .q_ready  (qd_ready),
        .q_data   (qd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/lwcc_log2.sv =====
// ============================================================================
// lwcc_log2: iterative fixed-point base-2 logarithm
// Normalizes the operand by a five-step binary shift search, then forms
// sixteen fraction bits by repeated squaring, one bit per cycle.
// ============================================================================
module lwcc_log2 (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [31:0]               operand,
    output logic                      done,
    output logic [lwcc_pkg::LOG_W-1:0] result
);
    import lwcc_pkg::*;

    localparam int unsigned NORM_STEPS = 5;
    localparam int unsigned SQR_STEPS  = LOG_FRAC_W;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } log_state_t;

    log_state_t              state_reg, state_next;
    logic [31:0]             m_reg, m_next;
    logic [4:0]              shift_reg, shift_next;
    logic [LOG_FRAC_W-1:0]   frac_reg, frac_next;
    logic [3:0]              step_reg, step_next;
    logic                    done_reg, done_next;

    logic [4:0]              norm_k;
    logic [31:0]             top_mask;
    logic [63:0]             sq;
    logic [32:0]             sq_sh;

    // Shift amount of the current normalization step: 16, 8, 4, 2, 1
    assign norm_k   = 5'(5'd16 >> step_reg);
    assign top_mask = ~(32'hFFFF_FFFF >> norm_k);
    assign sq       = m_reg * m_reg;
    assign sq_sh    = sq[63:31];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        shift_next = shift_reg;
        frac_next  = frac_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    m_next     = operand;
                    shift_next = '0;
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                if ((m_reg & top_mask) == 32'd0)
                begin
                    m_next     = m_reg << norm_k;
                    shift_next = shift_reg + norm_k;
                end
                if (step_reg == 4'(NORM_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = L_SQR;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            L_SQR:
            begin
                // m >= 2 after squaring: record a one and halve
                if (sq_sh[32])
                begin
                    m_next    = sq_sh[32:1];
                    frac_next = {frac_reg[LOG_FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_sh[31:0];
                    frac_next = {frac_reg[LOG_FRAC_W-2:0], 1'b0};
                end
                if (step_reg == 4'(SQR_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        shift_reg <= shift_next;
        frac_reg  <= frac_next;
        step_reg  <= step_next;
    end

    // Leading-one index is 31 minus the normalizing shift
    assign done   = done_reg;
    assign result = {5'(5'd31 - shift_reg), frac_reg};

endmodule

// ===== rtl/lwcc_front.sv =====
// ============================================================================
// lwcc_front: cell intake, weight computation and accumulation
// Accepts cells, decides whether each contributes, forms the logarithmic
// weight and accumulates the weighted sums; closed clusters go to the queue.
// ============================================================================
module lwcc_front #(
    parameter int unsigned MAX_CELLS = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lwcc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    input  logic [lwcc_pkg::WGT_W-1:0]         log_weight,
    output logic                               q_valid,
    input  logic                               q_ready,
    output lwcc_pkg::sums_t                    q_data
);
    import lwcc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_CELLS + 1);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_LOG  = 5'b00010,
        F_WGT  = 5'b00100,
        F_ACC  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t             state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [POS_W-1:0]         x_reg, z_reg;
    logic                     last_reg;
    logic signed [39:0]       prod_reg;
    logic [WGT_W-1:0]         w_reg;
    logic [SUMP_W-1:0]        sum_x_reg, sum_x_next;
    logic [SUMP_W-1:0]        sum_z_reg, sum_z_next;
    logic [SUMW_W-1:0]        sum_w_reg, sum_w_next;

    logic [POS_W-1:0]         in_x, in_z;
    logic [ENERGY_W-1:0]      in_e;
    logic [AMP_W-1:0]         in_a;
    logic                     accept;
    logic                     room;
    logic                     contrib;
    logic                     log_start;
    logic                     done_e, done_a;
    logic [LOG_W-1:0]         log_e, log_a;
    logic signed [21:0]       diff;
    logic signed [39:0]       t_val;

    // Unpack the cell: x, z, energy, amplitude from the lowest bit up
    assign in_x = s_tdata[5:0];
    assign in_z = s_tdata[11:6];
    assign in_e = s_tdata[27:12];
    assign in_a = s_tdata[51:28];

    assign s_tready  = (state_reg == F_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign room      = (cnt_reg < CNT_W'(MAX_CELLS));
    assign contrib   = room && (in_e != '0) && (in_a != '0);
    assign log_start = accept && contrib;

    // Logarithms of energy and amplitude, run side by side
    lwcc_log2 u_log_e (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand ({16'd0, in_e}),
        .done    (done_e),
        .result  (log_e)
    );

    lwcc_log2 u_log_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand ({8'd0, in_a}),
        .done    (done_a),
        .result  (log_a)
    );

    // log2(E) - log2(A), then offset plus scaled difference in Q.32
    assign diff  = $signed({1'b0, log_e}) - $signed({1'b0, log_a});
    assign t_val = $signed({4'd0, log_weight, 24'd0}) + prod_reg;

    // Sequencer and accumulators
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_x_next = sum_x_reg;
        sum_z_next = sum_z_reg;
        sum_w_next = sum_w_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    priority if (contrib)
                    begin
                        state_next = F_LOG;
                    end
                    else if (s_tlast)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_LOG:
            begin
                if (done_e && done_a)
                begin
                    state_next = F_WGT;
                end
            end
            F_WGT:
            begin
                state_next = F_ACC;
            end
            F_ACC:
            begin
                sum_x_next = sum_x_reg + SUMP_W'(w_reg) * SUMP_W'(x_reg);
                sum_z_next = sum_z_reg + SUMP_W'(w_reg) * SUMP_W'(z_reg);
                sum_w_next = sum_w_reg + SUMW_W'(w_reg);
                state_next = last_reg ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    cnt_next   = '0;
                    sum_x_next = '0;
                    sum_z_next = '0;
                    sum_w_next = '0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            sum_x_reg <= '0;
            sum_z_reg <= '0;
            sum_w_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_x_reg <= sum_x_next;
            sum_z_reg <= sum_z_next;
            sum_w_reg <= sum_w_next;
        end
    end

    // Cell payload and weight pipeline
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= in_x;
            z_reg    <= in_z;
            last_reg <= s_tlast;
        end
        if (state_reg == F_LOG)
        begin
            prod_reg <= diff * LN2_Q16;
        end
        if (state_reg == F_WGT)
        begin
            // Non-positive t gives zero, above 4095 saturates
            priority if (t_val[39] || (t_val == 40'sd0))
            begin
                w_reg <= '0;
            end
            else if (t_val[38:36] != 3'd0)
            begin
                w_reg <= WEIGHT_MAX;
            end
            else
            begin
                w_reg <= t_val[35:24];
            end
        end
    end

    assign q_valid      = (state_reg == F_PUSH);
    assign q_data.sum_x = sum_x_reg;
    assign q_data.sum_z = sum_z_reg;
    assign q_data.sum_w = sum_w_reg;

endmodule

// ===== rtl/lwcc_queue.sv =====
// ============================================================================
// lwcc_queue: short queue of closed cluster sums
// Decouples the accumulating front end from the division back end.
// ============================================================================
module lwcc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  lwcc_pkg::sums_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output lwcc_pkg::sums_t  pop_data
);
    import lwcc_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    sums_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/lwcc_divider.sv =====
// ============================================================================
// lwcc_divider: centroid division back end
// Pops closed cluster sums, divides both position sums by the weight sum
// with a restoring divider, one quotient bit per cycle, and holds the
// result in the output register.
// ============================================================================
module lwcc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  lwcc_pkg::sums_t               q_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lwcc_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser
);
    import lwcc_pkg::*;

    localparam int unsigned STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_DIV  = 3'b010,
        D_DONE = 3'b100
    } div_state_t;

    div_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [NUM_W-1:0]    num_x_reg, num_z_reg;
    logic [SUMW_W-1:0]   rem_x_reg, rem_z_reg;
    logic [SUMW_W-1:0]   div_reg;
    logic                zero_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg;

    logic                pop;
    logic                load_out;
    logic [SUMW_W+NUM_W-1:0] step_x, step_z;

    // One restoring step: returns {remainder, numerator/quotient}
    function automatic logic [SUMW_W+NUM_W-1:0] div_step(
        input logic [SUMW_W-1:0] rem,
        input logic [NUM_W-1:0]  num,
        input logic [SUMW_W-1:0] dvs
    );
        logic [SUMW_W:0]   r2;
        logic              ge;
        logic [SUMW_W-1:0] rem_new;
        r2      = {rem, num[NUM_W-1]};
        ge      = (r2 >= {1'b0, dvs});
        rem_new = ge ? SUMW_W'(r2 - {1'b0, dvs}) : r2[SUMW_W-1:0];
        return {rem_new, num[NUM_W-2:0], ge};
    endfunction

    assign step_x   = div_step(rem_x_reg, num_x_reg, div_reg);
    assign step_z   = div_step(rem_z_reg, num_z_reg, div_reg);
    assign q_ready  = (state_reg == D_IDLE);
    assign pop      = q_valid && q_ready;
    assign load_out = (state_reg == D_DONE) && (!out_valid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (pop)
                begin
                    state_next = (q_data.sum_w == '0) ? D_DONE : D_DIV;
                end
            end
            D_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                if (load_out)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= D_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider datapath and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // Empty weight sum: fields read as zero
            num_x_reg <= (q_data.sum_w == '0) ? '0 : {q_data.sum_x, FRAC_SHIFT'(0)};
            num_z_reg <= (q_data.sum_w == '0) ? '0 : {q_data.sum_z, FRAC_SHIFT'(0)};
            rem_x_reg <= '0;
            rem_z_reg <= '0;
            div_reg   <= q_data.sum_w;
            step_reg  <= '0;
            zero_reg  <= (q_data.sum_w == '0);
        end
        else if (state_reg == D_DIV)
        begin
            {rem_x_reg, num_x_reg} <= step_x;
            {rem_z_reg, num_z_reg} <= step_z;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (load_out)
        begin
            out_data_reg <= {4'd0, num_z_reg[CENT_W-1:0], num_x_reg[CENT_W-1:0]};
            out_user_reg <= !zero_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/lwcc_checker.sv =====
// ============================================================================
// lwcc_checker: port-level assertions for the cluster centroid block
// Watches the top-level streams and is attached by a bind statement.
// ============================================================================
module lwcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // An empty cluster reports zero centroid fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("empty cluster with nonzero centroid");

    // A mean position never exceeds cell 63, and the pad bits stay zero
    a_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[13:0] <= 14'd16128 &&
                                m_tdata[27:14] <= 14'd16128 &&
                                m_tdata[31:28] == 4'd0)
        else $error("centroid outside the cell grid");

    // Closing a cluster always takes the front end busy
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after a last cell");

endmodule

bind log_weighted_cluster_centroid lwcc_checker u_lwcc_checker (.*);
